### rtl/sparse_polynomial_engine_macros.svh
// Assertion macros used by the top level of the sparse polynomial engine.
`ifndef SPARSE_POLYNOMIAL_ENGINE_MACROS_SVH
`define SPARSE_POLYNOMIAL_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define SPE_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SPE_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SPE_ASSERT_IMP(label, clk, rst_n, a, c)
`define SPE_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### rtl/spe_pkg.sv
// Types and constants of the sparse polynomial engine.
`default_nettype none
package spe_pkg;
  localparam logic [2:0] FUNC_CLEAR = 3'd0;
  localparam logic [2:0] FUNC_LOAD_A = 3'd1;
  localparam logic [2:0] FUNC_LOAD_B = 3'd2;
  localparam logic [2:0] FUNC_ADD = 3'd3;
  localparam logic [2:0] FUNC_SUB = 3'd4;
  localparam logic [2:0] FUNC_EVAL_A = 3'd5;
  localparam logic [2:0] FUNC_EVAL_B = 3'd6;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam int RESULT_LIMIT = 32;

  typedef enum logic [3:0] {
    S_IDLE, S_MRD, S_MWAIT, S_MSTEP, S_MFLUSH, S_ERD, S_EWAIT, S_EPOW, S_EMUL,
    S_EACC, S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_counts;
    logic load_a;
    logic load_b;
    logic lat_in;
    logic idx_clr;
    logic merge_step;
    logic merge_flush;
    logic rd_eval;
    logic pow_init;
    logic pow_step;
    logic mul_term;
    logic acc_term;
    logic emit_load;
    logic emit_merge;
    logic emit_empty;
    logic emit_eval;
  } cmd_t;

  // Status returned to the controller.
  typedef struct packed {
    logic merge_more;
    logic eval_empty;
    logic eval_more;
    logic pow_done;
  } stat_t;
endpackage
`default_nettype wire

### rtl/sparse_polynomial_engine.sv
// Top level of the sparse polynomial engine.
//  channel | ports                                           | handshake
//  input   | in_func in_term_coeff in_term_exp in_x_value    | start high, busy low
//  result  | out_coeff out_exp out_eval_value ...            | out_valid, one cycle
// A merge primes the registered read of the term RAMs in a read state, repeats a
// wait and a step state per merge step, then sends the held final term in a flush
// state. Evaluation runs wait, power, multiply and accumulate states per term, the
// power loop using one 32x32 multiplier. Reset clears both counts at once.
// The receiver cannot stall; each result shows for one cycle.
`default_nettype none
`include "sparse_polynomial_engine_macros.svh"
module sparse_polynomial_engine #(
  parameter int MAX_TERMS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_func,
  input  wire logic signed [31:0] in_term_coeff,
  input  wire logic [5:0]         in_term_exp,
  input  wire logic signed [31:0] in_x_value,
  output logic                    out_valid,
  output logic signed [31:0]      out_coeff,
  output logic [5:0]              out_exp,
  output logic signed [31:0]      out_eval_value,
  output logic [1:0]              out_status,
  output logic                    out_last
);
  import spe_pkg::*;
  cmd_t  cmd;
  stat_t stat;

  spe_ctrl u_ctrl (.clk, .rst_n, .start, .in_func, .stat, .cmd, .busy);

  spe_datapath #(.MAX_TERMS(MAX_TERMS)) u_dp (.clk, .rst_n, .cmd, .stat,
    .in_func, .in_term_coeff, .in_term_exp, .in_x_value, .out_valid,
    .out_coeff, .out_exp, .out_eval_value, .out_status, .out_last);

  // A result never appears without the block being at work just before.
  `SPE_ASSERT_NEXT(a_idle_quiet, clk, rst_n, !busy && !start, !out_valid)
  // Non-last results come only from a merge, which keeps the block busy.
  `SPE_ASSERT_IMP(a_notlast_busy, clk, rst_n, out_valid && !out_last, busy)
endmodule
`default_nettype wire

### rtl/spe_ram.sv
// Generic RAM with one write port and one registered read port.
`default_nettype none
module spe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   raddr,
  output logic      [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/spe_datapath.sv
// Term stores, merge walker, evaluation unit and result register.
`default_nettype none
module spe_datapath #(
  parameter int MAX_TERMS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire spe_pkg::cmd_t        cmd,
  output spe_pkg::stat_t            stat,
  input  wire logic [2:0]           in_func,
  input  wire logic signed [31:0]   in_term_coeff,
  input  wire logic [5:0]           in_term_exp,
  input  wire logic signed [31:0]   in_x_value,
  output logic                      out_valid,
  output logic signed [31:0]        out_coeff,
  output logic [5:0]                out_exp,
  output logic signed [31:0]        out_eval_value,
  output logic [1:0]                out_status,
  output logic                      out_last
);
  import spe_pkg::*;
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int NW = $clog2(RESULT_LIMIT + 1);

  logic [CW-1:0] a_cnt_r, b_cnt_r, i_r, j_r;
  logic [NW-1:0] n_r;
  logic          sub_r, sel_b_r;
  logic [5:0]    lexp_a_r, lexp_b_r;
  logic [31:0]   x_r, pw_r, prod_r, acc_r;
  logic [5:0]    pcnt_r;
  logic [31:0]   c_in_r;
  logic [5:0]    e_in_r;
  logic [2:0]    func_r;
  logic          pv_r;
  logic [31:0]   pc_r;
  logic [5:0]    pe_r;

  // Load decision on the latched item.
  logic          ld_b;
  logic [CW-1:0] ld_cnt;
  logic [5:0]    ld_last;
  logic [1:0]    ld_st;
  always_comb begin
    ld_b = (func_r == FUNC_LOAD_B);
    ld_cnt = ld_b ? b_cnt_r : a_cnt_r;
    ld_last = ld_b ? lexp_b_r : lexp_a_r;
    if (ld_cnt >= CW'(MAX_TERMS)) ld_st = ST_FULL;
    else if (ld_cnt != '0 && e_in_r >= ld_last) ld_st = ST_ORDER;
    else ld_st = ST_OK;
  end
  logic wr_a, wr_b;
  assign wr_a = cmd.load_a && ld_st == ST_OK;
  assign wr_b = cmd.load_b && ld_st == ST_OK;

  // Read addresses: merge uses i and j, evaluation uses i on the chosen list.
  logic [AW-1:0] ra_a, ra_b;
  logic [CW-1:0] i_nx, j_nx;
  assign ra_a = i_nx[AW-1:0];
  assign ra_b = (cmd.rd_eval && sel_b_r) ? i_nx[AW-1:0] : j_nx[AW-1:0];
  logic [31:0] ac, bc;
  logic [5:0]  ae, be;

  spe_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_ac (.clk, .we(wr_a),
    .waddr(a_cnt_r[AW-1:0]), .wdata(c_in_r), .raddr(ra_a), .rdata(ac));
  spe_ram #(.WIDTH(6), .DEPTH(MAX_TERMS)) u_ae (.clk, .we(wr_a),
    .waddr(a_cnt_r[AW-1:0]), .wdata(e_in_r), .raddr(ra_a), .rdata(ae));
  spe_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_bc (.clk, .we(wr_b),
    .waddr(b_cnt_r[AW-1:0]), .wdata(c_in_r), .raddr(ra_b), .rdata(bc));
  spe_ram #(.WIDTH(6), .DEPTH(MAX_TERMS)) u_be (.clk, .we(wr_b),
    .waddr(b_cnt_r[AW-1:0]), .wdata(e_in_r), .raddr(ra_b), .rdata(be));

  // Merge choice on the registered heads.
  logic av, bv, take_a, take_b;
  logic [31:0] m_c;
  logic [5:0]  m_e;
  logic        m_emit;
  always_comb begin
    av = i_r < a_cnt_r;
    bv = j_r < b_cnt_r;
    take_a = av && (!bv || ae >= be);
    take_b = bv && (!av || be >= ae);
    m_e = take_a ? ae : be;
    if (take_a && take_b) m_c = sub_r ? ac - bc : ac + bc;
    else if (take_a) m_c = ac;
    else m_c = sub_r ? 32'd0 - bc : bc;
    m_emit = (take_a || take_b) && !(take_a && take_b && sub_r && m_c == 32'd0);
  end

  // Index updates.
  always_comb begin
    i_nx = i_r;
    j_nx = j_r;
    if (cmd.idx_clr) begin
      i_nx = '0;
      j_nx = '0;
    end else if (cmd.merge_step) begin
      if (take_a) i_nx = i_r + 1'b1;
      if (take_b) j_nx = j_r + 1'b1;
    end else if (cmd.acc_term) begin
      i_nx = i_r + 1'b1;
    end
  end

  logic [CW-1:0] ev_cnt;
  assign ev_cnt = sel_b_r ? b_cnt_r : a_cnt_r;
  logic [5:0] ev_e;
  logic [31:0] ev_c;
  assign ev_e = sel_b_r ? be : ae;
  assign ev_c = sel_b_r ? bc : ac;

  always_comb begin
    stat.merge_more = (i_nx < a_cnt_r || j_nx < b_cnt_r) &&
                      (n_r + NW'(m_emit)) < NW'(RESULT_LIMIT);
    stat.eval_empty = (ev_cnt == '0);
    stat.eval_more = (i_nx < ev_cnt);
    stat.pow_done = (pcnt_r == ev_e);
  end

  // Control registers: counts and the result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r <= '0;
      b_cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit_load || cmd.emit_empty || cmd.emit_eval ||
                   cmd.merge_flush || (cmd.emit_merge && m_emit && pv_r);
      if (cmd.clr_counts) begin
        a_cnt_r <= '0;
        b_cnt_r <= '0;
      end
      if (wr_a) a_cnt_r <= a_cnt_r + 1'b1;
      if (wr_b) b_cnt_r <= b_cnt_r + 1'b1;
    end
  end

  // Working registers of the merge and evaluation. A merge term is held
  // back one step so that the final kept term can carry last.
  always_ff @(posedge clk) begin
    i_r <= i_nx;
    j_r <= j_nx;
    if (cmd.idx_clr) begin
      n_r <= '0;
      pv_r <= 1'b0;
    end else if (cmd.merge_step && m_emit) begin
      n_r <= n_r + 1'b1;
      pv_r <= 1'b1;
    end
    if (cmd.merge_step && m_emit) begin
      pc_r <= m_c;
      pe_r <= m_e;
    end
    if (cmd.lat_in) begin
      func_r <= in_func;
      c_in_r <= in_term_coeff;
      e_in_r <= in_term_exp;
      x_r <= in_x_value;
      sub_r <= (in_func == FUNC_SUB);
      sel_b_r <= (in_func == FUNC_EVAL_B);
      acc_r <= '0;
    end
    if (wr_a) lexp_a_r <= e_in_r;
    if (wr_b) lexp_b_r <= e_in_r;
    if (cmd.pow_init) begin
      pw_r <= 32'd1;
      pcnt_r <= '0;
    end else if (cmd.pow_step) begin
      pw_r <= pw_r * x_r;
      pcnt_r <= pcnt_r + 1'b1;
    end
    if (cmd.mul_term) prod_r <= ev_c * pw_r;
    if (cmd.acc_term) acc_r <= acc_r + prod_r;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_coeff <= '0;
      out_exp <= '0;
      out_eval_value <= '0;
      out_status <= (func_r == FUNC_CLEAR) ? ST_OK : ld_st;
      out_last <= 1'b1;
    end else if (cmd.emit_empty) begin
      out_coeff <= '0;
      out_exp <= '0;
      out_eval_value <= '0;
      out_status <= ST_EMPTY;
      out_last <= 1'b1;
    end else if (cmd.emit_eval) begin
      out_coeff <= '0;
      out_exp <= '0;
      out_eval_value <= acc_r + prod_r;
      out_status <= ST_OK;
      out_last <= 1'b1;
    end else if (cmd.merge_flush) begin
      out_coeff <= pv_r ? pc_r : 32'd0;
      out_exp <= pv_r ? pe_r : 6'd0;
      out_eval_value <= '0;
      out_status <= pv_r ? ST_OK : ST_EMPTY;
      out_last <= 1'b1;
    end else if (cmd.emit_merge) begin
      out_coeff <= pc_r;
      out_exp <= pe_r;
      out_eval_value <= '0;
      out_status <= ST_OK;
      out_last <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### rtl/spe_ctrl.sv
// Controller state machine of the sparse polynomial engine.
`default_nettype none
module spe_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [2:0]    in_func,
  input  wire spe_pkg::stat_t stat,
  output spe_pkg::cmd_t      cmd,
  output logic               busy
);
  import spe_pkg::*;
  state_t state_r, state_nxt;
  logic [2:0] func_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    if (start && !busy) func_r <= in_func;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_func)
            FUNC_CLEAR, FUNC_LOAD_A, FUNC_LOAD_B: state_nxt = S_DONE;
            FUNC_ADD, FUNC_SUB: state_nxt = S_MRD;
            FUNC_EVAL_A, FUNC_EVAL_B: state_nxt = S_ERD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DONE: state_nxt = S_IDLE;
      S_MRD: state_nxt = S_MWAIT;
      S_MWAIT: state_nxt = S_MSTEP;
      S_MSTEP: begin
        if (!stat.merge_more) state_nxt = S_MFLUSH;
        else state_nxt = S_MWAIT;
      end
      S_MFLUSH: state_nxt = S_IDLE;
      S_ERD: state_nxt = stat.eval_empty ? S_IDLE : S_EWAIT;
      S_EWAIT: state_nxt = S_EPOW;
      S_EPOW: if (stat.pow_done) state_nxt = S_EMUL;
      S_EMUL: state_nxt = S_EACC;
      S_EACC: state_nxt = stat.eval_more ? S_EWAIT : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.lat_in = start;
        cmd.idx_clr = start;
      end
      S_DONE: begin
        cmd.clr_counts = (func_r == FUNC_CLEAR);
        cmd.load_a = (func_r == FUNC_LOAD_A);
        cmd.load_b = (func_r == FUNC_LOAD_B);
        cmd.emit_load = 1'b1;
      end
      S_MRD, S_MWAIT: ;
      S_MSTEP: begin
        cmd.merge_step = 1'b1;
        cmd.emit_merge = 1'b1;
      end
      S_MFLUSH: cmd.merge_flush = 1'b1;
      S_ERD: begin
        cmd.rd_eval = 1'b1;
        cmd.emit_empty = stat.eval_empty;
      end
      S_EWAIT: begin
        cmd.rd_eval = 1'b1;
        cmd.pow_init = 1'b1;
      end
      S_EPOW: begin
        cmd.rd_eval = 1'b1;
        cmd.pow_step = !stat.pow_done;
      end
      S_EMUL: begin
        cmd.rd_eval = 1'b1;
        cmd.mul_term = 1'b1;
      end
      S_EACC: begin
        cmd.rd_eval = 1'b1;
        cmd.acc_term = 1'b1;
        cmd.emit_eval = !stat.eval_more;
      end
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire
